FILE: rtl/core/amq_pkg.sv
`timescale 1ns / 1ps
// amq_pkg: shared constants and controller/datapath command and status types
// for the absmax int8 vector quantiser. No dependencies.
package amq_pkg;

   localparam int MAX_LEN_DEF = 64;

   // Magnitude bits of +Inf; anything above is a NaN
   localparam logic [30:0] MAG_INF = 31'h7F80_0000;
   // 127 as a 24-bit significand (1.984375 * 2^23), exponent 6
   localparam logic [23:0] DIVIDEND = 24'hFE_0000;
   localparam logic [4:0]  QUO_BITS = 5'd26;
   localparam logic [23:0] ONE_MANT = 24'h80_0000;

   // class of the scale factor
   typedef enum logic [1:0] {SC_NORM, SC_ZERO, SC_INF} scls_type;
   // class of one product before integer conversion
   typedef enum logic [1:0] {RC_ZERO, RC_SAT, RC_FIN} rcls_type;

   typedef struct packed {
      logic load;
      logic peak_norm_load;
      logic norm_step;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic elem_read;
      logic elem_norm_load;
      logic mul;
      logic rnd;
      logic cnv;
   } cmd_type;

   typedef struct packed {
      logic closing;
      logic norm_done;
      logic div_last;
      logic last_elem;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/amq_if.sv
`timescale 1ns / 1ps
// amq_if: valid/ready channel interfaces for the input and result words.
// No dependencies.
interface amq_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   logic        is_last;

   modport source (output valid, output value_bits, output is_last, input ready);
   modport sink   (input valid, input value_bits, input is_last, output ready);
endinterface

interface amq_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] quant_value;
   logic [5:0]        elem_index;
   logic              end_of_vector;

   modport source (output valid, output quant_value, output elem_index,
                   output end_of_vector, input ready);
   modport sink   (input valid, input quant_value, input elem_index,
                   input end_of_vector, output ready);
endinterface

FILE: rtl/core/absmax_int8_vector_quantize_unit.sv
`timescale 1ns / 1ps
// absmax_int8_vector_quantize_unit: top level, symmetric absmax int8 quantiser.
// Depends on amq_pkg, amq_if, amq_ctrl and amq_datapath.
//
// Usage
//  req_if carries one single-precision element per word; is_last closes the
//  vector, and so does the MAX_LEN-th word. rsp_if then gives one int8 word per
//  element in order, with its index and end_of_vector on the final one.
//  Load: one word per cycle while req_if.ready is high; ready drops from the
//  closing word until the last result sits in the output register.
//  Scale: 127 / peak by a restoring divider, one quotient bit a cycle; a
//  subnormal peak is first shifted up past its leading zeros.
//  Emission, element by element: store read, normalise (a subnormal element
//  is shifted up past its leading zeros), multiply, round, convert.
//  A stalled receiver holds the output register; the sequencer waits on it.
//  Reset (synchronous) empties the vector and clears the peak; store contents
//  are not cleared since only words of the current vector are read.
//  NaN products give 0; overflow saturates to 127 / -128.
module absmax_int8_vector_quantize_unit #(
   parameter int MAX_LEN = amq_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   amq_req_if.sink   req_if,
   amq_rsp_if.source rsp_if
);

   amq_pkg::cmd_type    cmd;
   amq_pkg::status_type status;

   amq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   amq_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value_bits    (req_if.value_bits),
      .req_is_last       (req_if.is_last),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_quant_value   (rsp_if.quant_value),
      .rsp_elem_index    (rsp_if.elem_index),
      .rsp_end_of_vector (rsp_if.end_of_vector)
   );

endmodule

FILE: rtl/core/amq_datapath.sv
`timescale 1ns / 1ps
// amq_datapath: sample store, peak tracker, normaliser, restoring divider,
// multiplier, rounding and int8 conversion, output register. Uses amq_pkg.
module amq_datapath #(
   parameter int MAX_LEN = amq_pkg::MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  amq_pkg::cmd_type     cmd,
   output amq_pkg::status_type  status,
   input  logic [31:0]          req_value_bits,
   input  logic                 req_is_last,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [7:0]    rsp_quant_value,
   output logic [5:0]           rsp_elem_index,
   output logic                 rsp_end_of_vector
);

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   typedef enum logic [1:0] {EC_FIN, EC_ZERO, EC_INF, EC_NAN} ecls_type;

   // store
   logic [31:0]        store_mem [MAX_LEN];
   logic [31:0]        rd_data_ff;

   logic [CNT_W-1:0]   fill_ff, fill_in, len_ff, len_in, fill_nxt;
   logic [30:0]        peak_ff, peak_in;
   logic [IDX_W-1:0]   emit_idx_ff, emit_idx_in;

   // normaliser
   logic [23:0]        norm_mant_ff, norm_mant_in;
   logic signed [9:0]  norm_exp_ff, norm_exp_in;
   logic               norm_done;
   logic [30:0]        norm_src;

   // divider
   logic [24:0]        rem_ff, rem_in, dvs, diff;
   logic [25:0]        quo_ff, quo_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               ge;

   // scale
   logic [23:0]        scale_mant_ff, scale_mant_in;
   logic signed [9:0]  scale_exp_ff, scale_exp_in;
   amq_pkg::scls_type  scls_ff, scls_in;

   logic [23:0]        qm;
   logic               qg, qs, qinc;
   logic [24:0]        qr;
   logic signed [9:0]  qe, qe_fin;

   // element
   logic               esign_ff, esign_in;
   ecls_type           ecls_ff, ecls_in;

   // product and rounding
   logic [47:0]        prod_ff, prod_in;
   logic signed [9:0]  pexp_ff, pexp_in;
   amq_pkg::rcls_type  rcls_ff, rcls_in;
   logic               psign_ff, psign_in;
   logic [24:0]        rm_ff, rm_in;
   logic signed [9:0]  re_ff, re_in;
   amq_pkg::rcls_type  rrcls_ff, rrcls_in;
   logic               rsign_ff, rsign_in;
   logic [23:0]        pm;
   logic               pg, ps;

   // conversion
   logic signed [9:0]  sh_full;
   logic [3:0]         sh;
   logic [33:0]        shifted, biased;
   logic [8:0]         tval;
   logic signed [7:0]  qv, sat_val;

   logic               valid_ff, valid_in;
   logic signed [7:0]  quant_ff;
   logic [5:0]         idx_ff;
   logic               end_ff;

   logic [30:0]        mag;
   logic               last_elem;

   assign mag       = req_value_bits[30:0];
   assign fill_nxt  = fill_ff + CNT_W'(1);
   assign last_elem = (CNT_W'(emit_idx_ff) + CNT_W'(1)) == len_ff;
   assign norm_done = norm_mant_ff[23] || (norm_mant_ff == 24'd0);

   assign status.closing   = req_is_last || (fill_nxt == CNT_W'(MAX_LEN));
   assign status.norm_done = norm_done;
   assign status.div_last  = (dcnt_ff == 5'd1);
   assign status.last_elem = last_elem;
   assign status.out_free  = !valid_ff || rsp_ready;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_mem[fill_ff[IDX_W-1:0]] <= req_value_bits;
      end
      if (cmd.elem_read) begin
         rd_data_ff <= store_mem[emit_idx_ff];
      end
   end

   // load side and index
   always_comb begin
      fill_in     = fill_ff;
      len_in      = len_ff;
      peak_in     = peak_ff;
      emit_idx_in = emit_idx_ff;
      if (cmd.load) begin
         if (status.closing) begin
            fill_in = '0;
            len_in  = fill_nxt;
         end else begin
            fill_in = fill_nxt;
         end
         if (mag <= amq_pkg::MAG_INF && mag > peak_ff) begin
            peak_in = mag;
         end
      end
      if (cmd.div_finish) begin
         peak_in     = '0;
         emit_idx_in = '0;
      end
      if (cmd.cnv && !last_elem) begin
         emit_idx_in = emit_idx_ff + IDX_W'(1);
      end
   end

   // normaliser: subnormals shifted up one bit a cycle
   always_comb begin
      norm_src     = cmd.peak_norm_load ? peak_ff : rd_data_ff[30:0];
      norm_mant_in = norm_mant_ff;
      norm_exp_in  = norm_exp_ff;
      if (cmd.peak_norm_load || cmd.elem_norm_load) begin
         if (norm_src[30:23] == 8'd0) begin
            norm_mant_in = {1'b0, norm_src[22:0]};
            norm_exp_in  = -10'sd126;
         end else begin
            norm_mant_in = {1'b1, norm_src[22:0]};
            norm_exp_in  = $signed({2'b00, norm_src[30:23]}) - 10'sd127;
         end
      end else if (cmd.norm_step && !norm_done) begin
         norm_mant_in = {norm_mant_ff[22:0], 1'b0};
         norm_exp_in  = norm_exp_ff - 10'sd1;
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      dvs     = {1'b0, norm_mant_ff};
      ge      = rem_ff >= dvs;
      diff    = ge ? (rem_ff - dvs) : rem_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         rem_in  = {1'b0, amq_pkg::DIVIDEND};
         quo_in  = '0;
         dcnt_in = amq_pkg::QUO_BITS;
      end else if (cmd.div_step && dcnt_ff != 5'd0) begin
         rem_in  = {diff[23:0], 1'b0};
         quo_in  = {quo_ff[24:0], ge};
         dcnt_in = dcnt_ff - 5'd1;
      end
   end

   // quotient normalise and round to nearest even
   always_comb begin
      if (quo_ff[25]) begin
         qm = quo_ff[25:2];
         qg = quo_ff[1];
         qs = quo_ff[0] || (rem_ff != 25'd0);
         qe = 10'sd6 - norm_exp_ff;
      end else begin
         qm = quo_ff[24:1];
         qg = quo_ff[0];
         qs = rem_ff != 25'd0;
         qe = 10'sd5 - norm_exp_ff;
      end
      qinc   = qg && (qs || qm[0]);
      qr     = {1'b0, qm} + 25'(qinc);
      qe_fin = qr[24] ? (qe + 10'sd1) : qe;

      scale_mant_in = scale_mant_ff;
      scale_exp_in  = scale_exp_ff;
      scls_in       = scls_ff;
      if (cmd.div_finish) begin
         scale_mant_in = qr[24] ? qr[24:1] : qr[23:0];
         scale_exp_in  = qe_fin;
         if (peak_ff == 31'd0) begin
            scale_mant_in = amq_pkg::ONE_MANT;
            scale_exp_in  = 10'sd0;
            scls_in       = amq_pkg::SC_NORM;
         end else if (peak_ff == amq_pkg::MAG_INF) begin
            scls_in = amq_pkg::SC_ZERO;
         end else if (qe_fin > 10'sd127) begin
            scls_in = amq_pkg::SC_INF;
         end else begin
            scls_in = amq_pkg::SC_NORM;
         end
      end
   end

   // element class, captured as it enters the normaliser
   always_comb begin
      esign_in = esign_ff;
      ecls_in  = ecls_ff;
      if (cmd.elem_norm_load) begin
         esign_in = rd_data_ff[31];
         if (rd_data_ff[30:23] == 8'hFF) begin
            ecls_in = (rd_data_ff[22:0] == 23'd0) ? EC_INF : EC_NAN;
         end else if (rd_data_ff[30:0] == 31'd0) begin
            ecls_in = EC_ZERO;
         end else begin
            ecls_in = EC_FIN;
         end
      end
   end

   // multiply
   always_comb begin
      prod_in  = prod_ff;
      pexp_in  = pexp_ff;
      rcls_in  = rcls_ff;
      psign_in = psign_ff;
      if (cmd.mul) begin
         prod_in  = norm_mant_ff * scale_mant_ff;
         pexp_in  = norm_exp_ff + scale_exp_ff;
         psign_in = esign_ff;
         case (ecls_ff)
            EC_NAN, EC_ZERO: rcls_in = amq_pkg::RC_ZERO;
            EC_INF: rcls_in = (scls_ff == amq_pkg::SC_ZERO) ? amq_pkg::RC_ZERO
                                                            : amq_pkg::RC_SAT;
            default: begin
               case (scls_ff)
                  amq_pkg::SC_ZERO: rcls_in = amq_pkg::RC_ZERO;
                  amq_pkg::SC_INF:  rcls_in = amq_pkg::RC_SAT;
                  default:          rcls_in = amq_pkg::RC_FIN;
               endcase
            end
         endcase
      end
   end

   // product to single precision, round to nearest even
   always_comb begin
      if (prod_ff[47]) begin
         pm = prod_ff[47:24];
         pg = prod_ff[23];
         ps = prod_ff[22:0] != 23'd0;
      end else begin
         pm = prod_ff[46:23];
         pg = prod_ff[22];
         ps = prod_ff[21:0] != 22'd0;
      end
      rm_in    = rm_ff;
      re_in    = re_ff;
      rrcls_in = rrcls_ff;
      rsign_in = rsign_ff;
      if (cmd.rnd) begin
         rm_in    = {1'b0, pm} + 25'(pg && (ps || pm[0]));
         re_in    = prod_ff[47] ? (pexp_ff + 10'sd1) : pexp_ff;
         rrcls_in = rcls_ff;
         rsign_in = psign_ff;
      end
   end

   // integer conversion: floor(|x| + 0.5), saturate
   always_comb begin
      sh_full = re_ff + 10'sd2;
      sh      = sh_full[3:0];
      shifted = {9'd0, rm_ff} << sh;
      biased  = shifted + 34'h100_0000;
      tval    = biased[33:25];
      sat_val = rsign_ff ? -8'sd128 : 8'sd127;
      case (rrcls_ff)
         amq_pkg::RC_ZERO: qv = 8'sd0;
         amq_pkg::RC_SAT:  qv = sat_val;
         default: begin
            if (re_ff > 10'sd6) begin
               qv = sat_val;
            end else if (re_ff < -10'sd2) begin
               qv = 8'sd0;
            end else if (rsign_ff) begin
               qv = (tval > 9'd128) ? -8'sd128 : $signed(8'(9'd0 - tval));
            end else begin
               qv = (tval > 9'd127) ? 8'sd127 : $signed(tval[7:0]);
            end
         end
      endcase
      valid_in = valid_ff;
      if (cmd.cnv) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         len_ff      <= '0;
         peak_ff     <= '0;
         emit_idx_ff <= '0;
         dcnt_ff     <= '0;
         valid_ff    <= 1'b0;
         scls_ff     <= amq_pkg::SC_ZERO;
      end else begin
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         peak_ff     <= peak_in;
         emit_idx_ff <= emit_idx_in;
         dcnt_ff     <= dcnt_in;
         valid_ff    <= valid_in;
         scls_ff     <= scls_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_mant_ff  <= norm_mant_in;
      norm_exp_ff   <= norm_exp_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      scale_mant_ff <= scale_mant_in;
      scale_exp_ff  <= scale_exp_in;
      esign_ff      <= esign_in;
      ecls_ff       <= ecls_in;
      prod_ff       <= prod_in;
      pexp_ff       <= pexp_in;
      rcls_ff       <= rcls_in;
      psign_ff      <= psign_in;
      rm_ff         <= rm_in;
      re_ff         <= re_in;
      rrcls_ff      <= rrcls_in;
      rsign_ff      <= rsign_in;
      if (cmd.cnv) begin
         quant_ff <= qv;
         idx_ff   <= 6'(emit_idx_ff);
         end_ff   <= last_elem;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_quant_value   = quant_ff;
   assign rsp_elem_index    = idx_ff;
   assign rsp_end_of_vector = end_ff;

endmodule

FILE: rtl/core/amq_ctrl.sv
`timescale 1ns / 1ps
// amq_ctrl: sequencer for load, scale division and per-element emission.
// Uses amq_pkg command and status types.
module amq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  amq_pkg::status_type status,
   output amq_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_PLOAD, S_PNORM, S_DSTART, S_DRUN, S_DFIN,
      S_RD, S_ELOAD, S_ENORM, S_MUL, S_RND, S_CNV
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd                = '0;
      cmd.load           = (state_ff == S_LOAD) && req_valid;
      cmd.peak_norm_load = (state_ff == S_PLOAD);
      cmd.norm_step      = (state_ff == S_PNORM) || (state_ff == S_ENORM);
      cmd.div_start      = (state_ff == S_DSTART);
      cmd.div_step       = (state_ff == S_DRUN);
      cmd.div_finish     = (state_ff == S_DFIN);
      cmd.elem_read      = (state_ff == S_RD);
      cmd.elem_norm_load = (state_ff == S_ELOAD);
      cmd.mul            = (state_ff == S_MUL);
      cmd.rnd            = (state_ff == S_RND);
      cmd.cnv            = (state_ff == S_CNV) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:   if (req_valid && status.closing) state_in = S_PLOAD;
         S_PLOAD:  state_in = S_PNORM;
         S_PNORM:  if (status.norm_done) state_in = S_DSTART;
         S_DSTART: state_in = S_DRUN;
         S_DRUN:   if (status.div_last) state_in = S_DFIN;
         S_DFIN:   state_in = S_RD;
         S_RD:     state_in = S_ELOAD;
         S_ELOAD:  state_in = S_ENORM;
         S_ENORM:  if (status.norm_done) state_in = S_MUL;
         S_MUL:    state_in = S_RND;
         S_RND:    state_in = S_CNV;
         S_CNV: begin
            if (status.out_free) begin
               state_in = status.last_elem ? S_LOAD : S_RD;
            end
         end
         default:  state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_LOAD);
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for absmax_int8_vector_quantize_unit.
// Depends on amq_pkg, amq_if and the quantiser RTL.
module tb_top;

   localparam int  VEC_DEPTH  = 64;
   localparam int  STALL_CAP  = 5000;
   localparam int  DRAIN_WAIT = 200;
   localparam real SUB_ULP    = 2.0 ** (-149);
   localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
   localparam logic [31:0] QNAN     = 32'h7FC0_0000;

   typedef struct {
      logic signed [7:0] quant;
      logic [5:0]        index;
      logic              eov;
   } qword_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   amq_req_if req_ch ();
   amq_rsp_if rsp_ch ();

   absmax_int8_vector_quantize_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [31:0] sample_mem [VEC_DEPTH];
   int          fill_level;
   logic [30:0] peak_mag;
   qword_type   expected_words [$];

   int  fail_count = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;
   int  rsp_stall_left = 0;

   // ---------------------------------------------------------------------
   // single-precision helpers: arithmetic done in double, rounded by hand
   // ---------------------------------------------------------------------
   function automatic real single_to_real(logic [31:0] b);
      real r;
      if (b[30:23] == 8'd0) begin
         r = real'(b[22:0]) * SUB_ULP;
         return b[31] ? -r : r;
      end
      return $bitstoreal({b[31], {3'b000, b[30:23]} + 11'd896, b[22:0], 29'd0});
   endfunction

   // round to nearest even, subnormals and overflow included
   function automatic logic [31:0] real_to_single(real x);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      longint      e;
      longint      bits;
      int          sh;
      d = $realtobits(x);
      if (d[62:52] == 11'd0)
         return {d[63], 31'd0};
      if (d[62:52] == 11'h7FF)
         return {d[63], 8'hFF, 23'd0};
      e  = longint'(d[62:52]) - 1023;
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + int'(-126 - e);
      if (sh > 60)
         sh = 60;
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0]))
         q = q + 64'd1;
      if (e >= -126)
         bits = ((e + 126) << 23) + longint'(q);
      else
         bits = longint'(q);
      if (bits >= longint'(32'h7F80_0000))
         return {d[63], 8'hFF, 23'd0};
      return {d[63], bits[30:0]};
   endfunction

   function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
      bit a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      a_nan  = a[30:0] > amq_pkg::MAG_INF;
      b_nan  = b[30:0] > amq_pkg::MAG_INF;
      a_inf  = a[30:0] == amq_pkg::MAG_INF;
      b_inf  = b[30:0] == amq_pkg::MAG_INF;
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
         return QNAN;
      if (a_inf || b_inf)
         return {a[31] ^ b[31], 8'hFF, 23'd0};
      return real_to_single(single_to_real(a) * single_to_real(b));
   endfunction

   // half away from zero, saturating; NaN gives 0
   function automatic logic signed [7:0] round_to_int8(logic [31:0] p);
      real x;
      real a;
      int  t;
      if (p[30:0] > amq_pkg::MAG_INF)
         return 8'sd0;
      if (p[30:0] == amq_pkg::MAG_INF)
         return p[31] ? -8'sd128 : 8'sd127;
      x = single_to_real(p);
      if (x >= 127.0)
         return 8'sd127;
      if (x <= -128.0)
         return -8'sd128;
      a = (x < 0.0) ? -x : x;
      t = $rtoi(a);
      if (a - real'(t) >= 0.5)
         t++;
      if (x < 0.0)
         t = -t;
      return 8'(t);
   endfunction

   function automatic logic [31:0] scale_for_peak(logic [30:0] pk);
      if (pk == 31'd0)
         return ONE_BITS;
      if (pk == amq_pkg::MAG_INF)
         return 32'd0;
      return real_to_single(127.0 / single_to_real({1'b0, pk}));
   endfunction

   // accepted element: update the vector, queue the words it releases
   function automatic void quantiser_absorb(logic [31:0] bits, logic last);
      logic [31:0] scale;
      qword_type   w;
      if (fill_level >= VEC_DEPTH)
         fill_level = 0;
      sample_mem[fill_level] = bits;
      fill_level++;
      // NaN magnitudes never exceed the peak
      if (bits[30:0] <= amq_pkg::MAG_INF && bits[30:0] > peak_mag)
         peak_mag = bits[30:0];
      if (!last && fill_level < VEC_DEPTH)
         return;
      scale = scale_for_peak(peak_mag);
      for (int i = 0; i < fill_level; i++) begin
         w.quant = round_to_int8(single_mul(sample_mem[i], scale));
         w.index = 6'(i);
         w.eov   = (i + 1 == fill_level);
         expected_words.push_back(w);
      end
      fill_level = 0;
      peak_mag   = 31'd0;
   endfunction

   // ---------------------------------------------------------------------
   // idling: mostly short gaps, now and then a long one
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 6);
   endfunction

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------
   task automatic send_word(logic [31:0] bits, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.value_bits <= bits;
      req_ch.is_last    <= last;
      do @(posedge clock); while (!req_ch.ready);
      quantiser_absorb(bits, last);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   // random element, biased towards well-scaled values
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return {1'($urandom), 8'($urandom_range(150, 110)), 23'($urandom)};
      if (r < 70)
         return $urandom;
      if (r < 76)
         return {1'($urandom), 31'd0};
      if (r < 80)
         return {1'($urandom), 8'hFF, 23'd0};
      if (r < 84)
         return {1'($urandom), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
      if (r < 94)
         return {1'($urandom), 8'd0, 23'($urandom)};
      return {1'($urandom), 8'($urandom_range(254, 1)), 23'($urandom)};
   endfunction

   task automatic send_vector(int len, bit mark_last);
      for (int i = 0; i < len; i++)
         send_word(pick_value(), mark_last && (i == len - 1));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_extremes();
      // signed zeros, largest finite of both signs and NaN in one vector
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7F7F_FFFF, 1'b0);
      send_word(32'hFF7F_FFFF, 1'b0);
      send_word(32'h7FC0_0001, 1'b1);
      // infinite peak: everything collapses to 0
      send_word(32'h3F80_0000, 1'b0);
      send_word(32'hFF80_0000, 1'b0);
      send_word(32'h7F80_0000, 1'b1);
      // all-zero vector keeps scale 1
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      // tiny peak: scale overflows, zero times infinity is NaN
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0001, 1'b1);
      // NaN only: peak stays zero
      send_word(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_rounding();
      // peak 127 gives scale exactly 1: halves round away from zero
      send_word(32'h42FE_0000, 1'b0);   // 127
      send_word(32'h3F00_0000, 1'b0);   // 0.5
      send_word(32'hBF00_0000, 1'b0);   // -0.5
      send_word(32'h3FC0_0000, 1'b0);   // 1.5
      send_word(32'hC020_0000, 1'b0);   // -2.5
      send_word(32'h3EFF_FFFF, 1'b0);   // just under 0.5
      send_word(32'hC2FE_0000, 1'b1);   // -127
   endtask

   task automatic test_store_full();
      // no closing mark: the 64th word closes the vector
      send_vector(VEC_DEPTH, 1'b0);
      send_vector(VEC_DEPTH, 1'b1);
   endtask

   task automatic test_random_vectors(int target);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(99);
         if (r < 70)
            len = $urandom_range(8, 1);
         else if (r < 92)
            len = $urandom_range(30, 9);
         else
            len = VEC_DEPTH;
         // stretches with no idling on either side
         no_idle = ($urandom_range(9) == 0);
         send_vector(len, (len < VEC_DEPTH) ? 1'b1 : 1'($urandom));
         sent += len;
         if ($urandom_range(19) == 0)
            wait_drained();
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // result side: random stall, check each word against the queue
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      qword_type w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word q=%0d idx=%0d eov=%0b", $realtime,
                        rsp_ch.quant_value, rsp_ch.elem_index, rsp_ch.end_of_vector);
            end else begin
               w = expected_words.pop_front();
               if (rsp_ch.quant_value !== w.quant) begin
                  fail_count++;
                  $display("%0t: quant_value expected %0d actual %0d", $realtime,
                           w.quant, rsp_ch.quant_value);
               end
               if (rsp_ch.elem_index !== w.index) begin
                  fail_count++;
                  $display("%0t: elem_index expected %0d actual %0d", $realtime,
                           w.index, rsp_ch.elem_index);
               end
               if (rsp_ch.end_of_vector !== w.eov) begin
                  fail_count++;
                  $display("%0t: end_of_vector expected %0b actual %0b", $realtime,
                           w.eov, rsp_ch.end_of_vector);
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready   <= 1'b1;
            rsp_stall_left = pick_gap();
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.value_bits = 32'd0;
      req_ch.is_last    = 1'b0;
      fill_level        = 0;
      peak_mag          = 31'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_rounding();
      test_store_full();
      wait_drained();
      test_random_vectors(350);

      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/amq_pkg.sv
rtl/core/amq_if.sv
rtl/core/amq_datapath.sv
rtl/core/amq_ctrl.sv
rtl/core/absmax_int8_vector_quantize_unit.sv
bench/tb_top.sv
